// ----- hdl/srg_pkg.sv -----
package srg_pkg;

   localparam int unsigned VAL_W = 30;
   localparam int unsigned SEED_W = 28;
   localparam int unsigned ADDR_W = 6;

   localparam int unsigned TBL_LEN = 55;
   localparam int unsigned STRIDE = 21;
   localparam int unsigned MIX_OFFSET = 31;
   localparam int unsigned SECOND_START = 31;
   localparam int unsigned PTR_WRAP = 56;
   localparam int unsigned MIX_PASSES = 4;

   localparam logic [SEED_W-1:0] MSEED = 28'd176234574;
   localparam logic [VAL_W-1:0] VAL_MOD = 30'd1000000000;

   typedef logic [VAL_W-1:0] value_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_FILL,
      ST_MIX_RD,
      ST_MIX_WR,
      ST_DRAW_RD,
      ST_DRAW_WR
   } srg_state_type;

endpackage

// ----- hdl/srg_sub_mod.sv -----
// (a - b) modulo one billion, both operands below one billion
module srg_sub_mod (
   input  srg_pkg::value_type minuend,
   input  srg_pkg::value_type subtrahend,
   output srg_pkg::value_type diff
);
   import srg_pkg::*;

   logic [VAL_W:0] raw;

   always_comb begin
      raw = {1'b0, minuend} - {1'b0, subtrahend};
      if (raw[VAL_W]) begin
         diff = raw[VAL_W-1:0] + VAL_MOD;
      end else begin
         diff = raw[VAL_W-1:0];
      end
   end

endmodule

// ----- hdl/subtractive_random_generator_core.sv -----
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_command (1), req_seed (28)
// rsp       out        rsp_valid / rsp_stall   rsp_random_value (30)
//
// a draw reads both lag entries on the accept edge, then at its write-back step
// writes the difference back and loads the output register
// a reseed (or the first transfer after reset) runs the accept step, 1 seed write,
// 54 fill writes, 4 x 55 read/write pairs of mixing, then a read and a write-back;
// the single modular subtractor and the one write port set these counts
// reset (synchronous) resets the sequencer, pointers, table-ready flag and rsp_valid
// req is stalled while an item is in progress; a stalled rsp holds the draw at its
// write-back step, and a new req transfer is taken while a result waits
module subtractive_random_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [27:0]        req_seed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output srg_pkg::value_type rsp_random_value
);
   import srg_pkg::*;

   // pointer step: 1..55, wrapping from 55 back to 1
   function automatic addr_type ptr_advance(input addr_type p);
      logic [ADDR_W:0] nxt;
      nxt = {1'b0, p} + (ADDR_W+1)'(1);
      if (nxt >= (ADDR_W+1)'(PTR_WRAP)) begin
         return addr_type'(1);
      end
      return nxt[ADDR_W-1:0];
   endfunction

   // sequencer and control state
   srg_state_type state_ff, state_in;
   logic          table_ready_ff, table_ready_in;
   addr_type      first_ptr_ff, first_ptr_in;
   addr_type      second_ptr_ff, second_ptr_in;
   addr_type      slot_ff, slot_in;     // fill slot, then mixing index
   addr_type      count_ff, count_in;   // fill step count
   logic [1:0]    pass_ff, pass_in;     // mixing pass
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [SEED_W-1:0] seed_ff, seed_in;
   value_type         prev_ff, prev_in;
   value_type         cur_ff, cur_in;
   value_type         rsp_value_ff, rsp_value_in;

   // lag table memory: one write port, two registered read ports
   value_type lag_mem [TBL_LEN];
   value_type rd_a_ff, rd_b_ff;
   logic      mem_we, mem_re;
   addr_type  mem_waddr, rd_addr_a, rd_addr_b;
   value_type mem_wdata;

   // shared modular subtractor
   value_type op_a, op_b, sub_diff;

   logic              out_free;
   logic [SEED_W-1:0] start_word;
   logic [ADDR_W:0]   slot_sum, other_sum;
   addr_type          slot_step, mix_other;

   srg_sub_mod u_sub (
      .minuend    (op_a),
      .subtrahend (op_b),
      .diff       (sub_diff)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // seed word is the distance from the fixed start constant
   assign start_word = (seed_ff <= MSEED) ? (MSEED - seed_ff) : (seed_ff - MSEED);

   // fill slots step by 21 modulo 55
   assign slot_sum  = {1'b0, slot_ff} + (ADDR_W+1)'(STRIDE);
   assign slot_step = (slot_sum >= (ADDR_W+1)'(TBL_LEN)) ?
                      ADDR_W'(slot_sum - (ADDR_W+1)'(TBL_LEN)) : slot_sum[ADDR_W-1:0];

   // mixing partner is 31 slots ahead, modulo 55
   assign other_sum = {1'b0, slot_ff} + (ADDR_W+1)'(MIX_OFFSET);
   assign mix_other = (other_sum >= (ADDR_W+1)'(TBL_LEN)) ?
                      ADDR_W'(other_sum - (ADDR_W+1)'(TBL_LEN)) : other_sum[ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (!req_command && table_ready_ff) ? ST_DRAW_WR : ST_SEED;
            end
         end
         ST_SEED: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (count_ff == addr_type'(TBL_LEN - 1)) begin
               state_in = ST_MIX_RD;
            end
         end
         ST_MIX_RD: begin
            state_in = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            if (slot_ff == addr_type'(TBL_LEN - 1) && pass_ff == 2'(MIX_PASSES - 1)) begin
               state_in = ST_DRAW_RD;
            end else begin
               state_in = ST_MIX_RD;
            end
         end
         ST_DRAW_RD: begin
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      table_ready_in = table_ready_ff;
      first_ptr_in   = first_ptr_ff;
      second_ptr_in  = second_ptr_ff;
      slot_in        = slot_ff;
      count_in       = count_ff;
      pass_in        = pass_ff;
      seed_in        = seed_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      mem_we         = 1'b0;
      mem_waddr      = slot_ff;
      mem_wdata      = sub_diff;
      mem_re         = 1'b0;
      rd_addr_a      = slot_ff;
      rd_addr_b      = mix_other;
      op_a           = rd_a_ff;
      op_b           = rd_b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seed_in = req_seed;
               // plain draw on a built table: read both taps on the transfer edge
               if (!req_command && table_ready_ff) begin
                  first_ptr_in  = ptr_advance(first_ptr_ff);
                  second_ptr_in = ptr_advance(second_ptr_ff);
                  mem_re        = 1'b1;
                  rd_addr_a     = first_ptr_in - addr_type'(1);
                  rd_addr_b     = second_ptr_in - addr_type'(1);
               end
            end
         end
         ST_SEED: begin
            // last slot gets the start word
            mem_we        = 1'b1;
            mem_waddr     = addr_type'(TBL_LEN - 1);
            mem_wdata     = value_type'(start_word);
            prev_in       = value_type'(start_word);
            cur_in        = value_type'(1);
            slot_in       = addr_type'(STRIDE - 1);
            count_in      = addr_type'(1);
            first_ptr_in  = '0;
            second_ptr_in = addr_type'(SECOND_START);
         end
         ST_FILL: begin
            op_a      = prev_ff;
            op_b      = cur_ff;
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = cur_ff;
            prev_in   = cur_ff;
            cur_in    = sub_diff;
            count_in  = count_ff + addr_type'(1);
            if (count_ff == addr_type'(TBL_LEN - 1)) begin
               slot_in = '0;
               pass_in = '0;
            end else begin
               slot_in = slot_step;
            end
         end
         ST_MIX_RD: begin
            mem_re    = 1'b1;
            rd_addr_a = slot_ff;
            rd_addr_b = mix_other;
         end
         ST_MIX_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            if (slot_ff == addr_type'(TBL_LEN - 1)) begin
               slot_in = '0;
               pass_in = pass_ff + 2'd1;
               if (pass_ff == 2'(MIX_PASSES - 1)) begin
                  table_ready_in = 1'b1;
               end
            end else begin
               slot_in = slot_ff + addr_type'(1);
            end
         end
         ST_DRAW_RD: begin
            first_ptr_in  = ptr_advance(first_ptr_ff);
            second_ptr_in = ptr_advance(second_ptr_ff);
            mem_re        = 1'b1;
            rd_addr_a     = first_ptr_in - addr_type'(1);
            rd_addr_b     = second_ptr_in - addr_type'(1);
         end
         ST_DRAW_WR: begin
            // write-back and result load happen together, held while rsp is full
            if (out_free) begin
               mem_we       = 1'b1;
               mem_waddr    = first_ptr_ff - addr_type'(1);
               rsp_valid_in = 1'b1;
               rsp_value_in = sub_diff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lag_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= lag_mem[rd_addr_a];
         rd_b_ff <= lag_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         table_ready_ff <= 1'b0;
         first_ptr_ff   <= '0;
         second_ptr_ff  <= addr_type'(SECOND_START);
         slot_ff        <= '0;
         count_ff       <= '0;
         pass_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_ready_ff <= table_ready_in;
         first_ptr_ff   <= first_ptr_in;
         second_ptr_ff  <= second_ptr_in;
         slot_ff        <= slot_in;
         count_ff       <= count_in;
         pass_ff        <= pass_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff      <= seed_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // the two taps always stay 31 apart around the 55-entry ring
   a_ptr_spacing: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, second_ptr_ff} == {1'b0, first_ptr_ff} + 7'd31) ||
      ({1'b0, first_ptr_ff} == {1'b0, second_ptr_ff} + 7'd24))
      else $error("lag pointers lost their spacing");

   // a new result only appears out of the write-back step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DRAW_WR))
      else $error("result loaded outside write-back");

   // no draw writes back into a table that was never built
   a_draw_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_WR) |-> table_ready_ff)
      else $error("draw on an unbuilt table");

endmodule

// ----- sim/srg_result_checker.sv -----
`timescale 1ns / 1ps

module srg_result_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_command,
   input  logic [srg_pkg::SEED_W-1:0] req_seed,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  srg_pkg::value_type        rsp_random_value,
   output int                        mismatch_count,
   output int                        pending_count
);

   import srg_pkg::value_type;

   localparam int unsigned BASE_SEED       = 176234574;
   localparam int unsigned MODULUS         = 1000000000;
   localparam int unsigned WORDS           = 55;
   localparam int unsigned STRIDE_STEP     = 21;
   localparam int unsigned MIX_SLOT_OFFSET = 30;
   localparam int unsigned TRAIL_START     = 31;
   localparam int unsigned PTR_LIMIT       = 56;
   localparam int unsigned WARMUP_PASSES   = 4;
   localparam int          REPORT_LIMIT    = 10;

   value_type   lag_words [WORDS];
   int unsigned lead_ptr;
   int unsigned trail_ptr;
   bit          words_ready;
   value_type   expected_values [$];
   int          errors;

   // difference modulo one billion
   function automatic value_type mod_diff(value_type a, value_type b);
      int unsigned ua;
      int unsigned ub;
      ua = a;
      ub = b;
      if (ua >= ub) begin
         return value_type'(ua - ub);
      end
      return value_type'(ua + MODULUS - ub);
   endfunction

   function automatic int unsigned step_ptr(int unsigned p);
      p = p + 1;
      if (p >= PTR_LIMIT) begin
         p = 1;
      end
      return p;
   endfunction

   task automatic rebuild_words(input logic [srg_pkg::SEED_W-1:0] seed);
      int unsigned s;
      int unsigned start;
      value_type   prev;
      value_type   cur;
      int unsigned pos;
      int unsigned other;
      s = seed;
      start = (s <= BASE_SEED) ? (BASE_SEED - s) : (s - BASE_SEED);
      start = start % MODULUS;
      lag_words[WORDS-1] = value_type'(start);
      prev = value_type'(start);
      cur = value_type'(1);
      for (int unsigned i = 1; i < WORDS; i++) begin
         pos = (STRIDE_STEP * i) % WORDS;
         lag_words[pos-1] = cur;
         cur = mod_diff(prev, cur);
         prev = lag_words[pos-1];
      end
      // warm-up passes
      for (int unsigned pass = 0; pass < WARMUP_PASSES; pass++) begin
         for (int unsigned i = 1; i <= WORDS; i++) begin
            other = (i + MIX_SLOT_OFFSET) % WORDS;
            lag_words[i-1] = mod_diff(lag_words[i-1], lag_words[other]);
         end
      end
      lead_ptr = 0;
      trail_ptr = TRAIL_START;
      words_ready = 1'b1;
   endtask

   task automatic draw_value(input logic cmd, input logic [srg_pkg::SEED_W-1:0] seed,
                             output value_type value);
      if (cmd || !words_ready) begin
         rebuild_words(seed);
      end
      lead_ptr = step_ptr(lead_ptr);
      trail_ptr = step_ptr(trail_ptr);
      value = mod_diff(lag_words[lead_ptr-1], lag_words[trail_ptr-1]);
      lag_words[lead_ptr-1] = value;
   endtask

   always @(posedge clock) begin
      value_type want;
      value_type next_want;
      if (reset) begin
         lead_ptr = 0;
         trail_ptr = TRAIL_START;
         words_ready = 1'b0;
         expected_values.delete();
         errors = 0;
      end else begin
         // results first: a result never belongs to a request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("unexpected result transfer: random_value %0d", rsp_random_value);
               end
            end else begin
               want = expected_values.pop_front();
               if (want !== rsp_random_value) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("random_value mismatch: expected %0d, actual %0d",
                              want, rsp_random_value);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            draw_value(req_command, req_seed, next_want);
            expected_values.push_back(next_want);
         end
      end
      mismatch_count <= errors;
      pending_count <= expected_values.size();
   end

endmodule

// ----- sim/tb_subtractive_random_generator_core.sv -----
`timescale 1ns / 1ps

module tb_subtractive_random_generator_core;

   import srg_pkg::*;

   // the quiet-cycle limit leaves plenty of room on top of a full reseed
   // and the longest receiver stall
   localparam int QUIET_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 550;
   localparam int PHASE_ITEMS   = RANDOM_ITEMS / 3;
   localparam logic [SEED_W-1:0] SEED_ALL_ONES = '1;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_command;
   logic [SEED_W-1:0] req_seed;
   logic              rsp_valid;
   logic              rsp_stall;
   value_type         rsp_random_value;

   int                mismatch_count;
   int                pending_count;

   // idle percentages, changed per phase
   int                send_idle;
   int                recv_idle;
   int                quiet_cycles;

   subtractive_random_generator_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   srg_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver side: random stall decided at each falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // watchdog: counts cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_subtractive_random_generator_core failed");
         $finish;
      end
   end

   // one request transfer; valid stays high into the next item unless a gap is drawn,
   // so valid only ever gets one assignment per falling edge
   task automatic send_item(input logic cmd, input logic [SEED_W-1:0] seed);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_seed <= seed;
      // hold the payload until the transfer edge
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // seeds: mostly inside the published range, some over the whole field, some edges
   function automatic logic [SEED_W-1:0] pick_seed();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return '0;
               1: return MSEED;
               2: return MSEED + 1;
               default: return SEED_ALL_ONES;
            endcase
         end
         1, 2: return SEED_W'($urandom) & SEED_ALL_ONES;
         default: return SEED_W'($urandom_range(MSEED, 0));
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         // reseeds are rare, draws carry the generator deep into its sequence
         send_item($urandom_range(15) == 0, pick_seed());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_seed = '0;
      send_idle = 10;
      recv_idle = 53;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      // first transfer after reset builds the table although command is a draw
      send_item(1'b0, 28'd12345);
      // draws ignore the seed field
      send_item(1'b0, SEED_ALL_ONES);
      send_item(1'b0, '0);
      send_item(1'b0, 28'h5555555);
      // reseed from zero, then draw on
      send_item(1'b1, '0);
      send_item(1'b0, '0);
      send_item(1'b0, '0);
      // seed equal to the base word: table starts from zero
      send_item(1'b1, MSEED);
      send_item(1'b0, '0);
      // seeds above the base word use the absolute difference
      send_item(1'b1, MSEED + 1);
      send_item(1'b0, '0);
      send_item(1'b1, SEED_ALL_ONES);
      send_item(1'b0, SEED_ALL_ONES);
      send_item(1'b1, 28'd1);
      send_item(1'b1, 28'h5555555);
      send_item(1'b1, 28'hAAAAAAA);
      send_item(1'b0, '0);
      // two reseeds with the same seed, each followed by a draw, restart the same sequence
      send_item(1'b1, 28'd161803398);
      send_item(1'b0, '0);
      send_item(1'b1, 28'd161803398);
      send_item(1'b0, '0);

      // random part, three idle profiles
      send_random(PHASE_ITEMS);
      send_idle = 53;
      recv_idle = 10;
      send_random(PHASE_ITEMS);
      send_idle = 0;
      recv_idle = 0;
      send_random(RANDOM_ITEMS - 2 * PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;

      // wait for every result, the watchdog bounds this
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_subtractive_random_generator_core passed");
      end else begin
         $display("tb_subtractive_random_generator_core failed");
      end
      $finish;
   end

endmodule

// ----- subtractive_random_generator_core.f -----
hdl/srg_pkg.sv
hdl/srg_sub_mod.sv
hdl/subtractive_random_generator_core.sv
sim/srg_result_checker.sv
sim/tb_subtractive_random_generator_core.sv
